### hdl/ptb_pkg.sv
// Package for the periodic timer bank: command codes, controller states and control structs.
package ptb_pkg;

  // Command codes carried by the command field.
  typedef enum logic [3:0] {
    CMD_TICK         = 4'd0,
    CMD_DISPATCH     = 4'd1,
    CMD_ALLOCATE     = 4'd2,
    CMD_FREE         = 4'd3,
    CMD_SET_INTERVAL = 4'd4,
    CMD_START        = 4'd5,
    CMD_STOP         = 4'd6,
    CMD_READ_TICKS   = 4'd7,
    CMD_READ_COUNT   = 4'd8,
    CMD_CLEAR        = 4'd9
  } cmd_e;

  // A dispatch reports at most this many fired slots.
  localparam int         FIRE_W   = 5;
  localparam logic [4:0] MAX_FIRE = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TCK_RD,
    S_TCK_EV,
    S_DSP_RD,
    S_DSP_EV,
    S_ALC,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic idx_inc;
    logic tick_eval;
    logic disp_eval;
    logic alloc_eval;
    logic emit;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e in_cmd;
    logic in_ival_zero;
    logic idx_last;
    logic slot_free;
    logic fire_here;
    logic pend;
    logic out_free;
  } sts_t;

endpackage

### hdl/ptb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ptb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ptb_ctrl.sv
// Controller state machine for the periodic timer bank.
module ptb_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  ptb_pkg::sts_t sts,
  output ptb_pkg::ctl_t ctl
);
  import ptb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.accept = 1'b1;
          case (sts.in_cmd)
            CMD_TICK:     state_next = S_TCK_RD;
            CMD_DISPATCH: state_next = S_DSP_RD;
            CMD_ALLOCATE: state_next = sts.in_ival_zero ? S_RESP : S_ALC;
            default:      state_next = S_RESP;
          endcase
        end
      end
      S_TCK_RD: state_next = S_TCK_EV;
      S_TCK_EV: begin
        ctl.tick_eval = 1'b1;
        if (sts.idx_last) begin
          state_next = S_RESP;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_TCK_RD;
        end
      end
      S_DSP_RD: state_next = S_DSP_EV;
      S_DSP_EV: begin
        // A new fire needs the output register for the one still pending.
        if (!(sts.fire_here && sts.pend && !sts.out_free)) begin
          ctl.disp_eval = 1'b1;
          if (sts.idx_last) begin
            state_next = S_RESP;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_DSP_RD;
          end
        end
      end
      S_ALC: begin
        ctl.alloc_eval = 1'b1;
        if (sts.slot_free || sts.idx_last) begin
          state_next = S_RESP;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### hdl/ptb_datapath.sv
// Datapath of the periodic timer bank: slot flags, period and remaining RAMs, counters, output.
module ptb_datapath #(
  parameter int NUM_SLOTS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  ptb_pkg::ctl_t ctl,
  output ptb_pkg::sts_t sts,
  input  logic [3:0]    command,
  input  logic [3:0]    slot,
  input  logic [31:0]   interval,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          status,
  output logic [3:0]    slot_out,
  output logic          fired,
  output logic          last,
  output logic [31:0]   tick_count,
  output logic [4:0]    timer_count
);
  import ptb_pkg::*;

  localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  logic [NUM_SLOTS-1:0] used;
  logic [NUM_SLOTS-1:0] enabled;
  logic [CNT_W-1:0]     count;
  logic [31:0]          ticks;
  logic [IDX_W-1:0]     idx;
  logic [31:0]          ival_r;
  logic [FIRE_W-1:0]    fire_cnt;
  logic                 resp_status;
  logic                 resp_fired;
  logic [IDX_W-1:0]     resp_slot;

  logic                 per_we, rem_we;
  logic [IDX_W-1:0]     per_waddr, rem_waddr;
  logic [31:0]          per_wdata, rem_wdata, per_rdata, rem_rdata;

  cmd_e                 in_cmd;
  logic [IDX_W-1:0]     slot_idx;
  logic                 slot_ok;
  logic                 ival_zero;
  logic                 cur_active;
  logic                 fire_here;
  logic                 out_free;
  logic                 push_pend;
  logic                 idx_last;

  assign in_cmd     = cmd_e'(command);
  assign slot_idx   = IDX_W'(slot);
  assign slot_ok    = (int'(slot) < NUM_SLOTS) && used[slot_idx];
  assign ival_zero  = (interval == 32'd0);
  assign cur_active = used[idx] && enabled[idx];
  assign fire_here  = cur_active && (rem_rdata == 32'd0) && (fire_cnt != MAX_FIRE);
  assign out_free   = !out_valid || !out_stall;
  assign push_pend  = ctl.disp_eval && fire_here && resp_fired;
  assign idx_last   = (idx == IDX_W'(NUM_SLOTS - 1));

  always_comb begin
    sts.in_cmd       = in_cmd;
    sts.in_ival_zero = ival_zero;
    sts.idx_last     = idx_last;
    sts.slot_free    = !used[idx];
    sts.fire_here    = fire_here;
    sts.pend         = resp_fired;
    sts.out_free     = out_free;
  end

  // RAM write ports; the cases below never coincide.
  always_comb begin
    per_we    = 1'b0;
    per_waddr = idx;
    per_wdata = ival_r;
    rem_we    = 1'b0;
    rem_waddr = idx;
    rem_wdata = ival_r;
    if (ctl.accept && in_cmd == CMD_SET_INTERVAL && slot_ok && !ival_zero) begin
      per_we    = 1'b1;
      per_waddr = slot_idx;
      per_wdata = interval;
    end
    if (ctl.alloc_eval && !used[idx]) begin
      per_we = 1'b1;
      rem_we = 1'b1;
    end
    if (ctl.tick_eval && cur_active && rem_rdata != 32'd0) begin
      rem_we    = 1'b1;
      rem_wdata = rem_rdata - 32'd1;
    end
    if (ctl.disp_eval && fire_here) begin
      rem_we    = 1'b1;
      rem_wdata = per_rdata;
    end
  end

  ptb_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_period (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (idx),
    .rdata (per_rdata)
  );

  ptb_ram #(.WIDTH(32), .DEPTH(NUM_SLOTS)) u_remaining (
    .clk   (clk),
    .we    (rem_we),
    .waddr (rem_waddr),
    .wdata (rem_wdata),
    .raddr (idx),
    .rdata (rem_rdata)
  );

  // Slot flags, counters and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      enabled   <= '0;
      count     <= '0;
      ticks     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.accept) begin
        case (in_cmd)
          CMD_TICK: ticks <= ticks + 32'd1;
          CMD_FREE: begin
            if (slot_ok) begin
              used[slot_idx]    <= 1'b0;
              enabled[slot_idx] <= 1'b0;
              count             <= count - CNT_W'(1);
            end
          end
          CMD_START, CMD_STOP: begin
            if (slot_ok) begin
              enabled[slot_idx] <= (in_cmd == CMD_START);
            end
          end
          CMD_CLEAR: begin
            used    <= '0;
            enabled <= '0;
            count   <= '0;
          end
          default: ;
        endcase
      end
      if (ctl.alloc_eval && !used[idx]) begin
        used[idx]    <= 1'b1;
        enabled[idx] <= 1'b0;
        count        <= count + CNT_W'(1);
      end
      if (push_pend || ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Sweep index, response fields and output payload.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      idx        <= '0;
      ival_r     <= interval;
      fire_cnt   <= '0;
      resp_slot  <= '0;
      resp_fired <= 1'b0;
      case (in_cmd)
        CMD_TICK, CMD_DISPATCH, CMD_READ_TICKS, CMD_READ_COUNT, CMD_CLEAR:
          resp_status <= 1'b0;
        CMD_ALLOCATE:     resp_status <= 1'b1;
        CMD_FREE, CMD_START, CMD_STOP:
          resp_status <= !slot_ok;
        CMD_SET_INTERVAL: resp_status <= !(slot_ok && !ival_zero);
        default:          resp_status <= 1'b1;
      endcase
    end
    if (ctl.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (ctl.alloc_eval && !used[idx]) begin
      resp_slot   <= idx;
      resp_status <= 1'b0;
    end
    if (ctl.disp_eval && fire_here) begin
      fire_cnt   <= fire_cnt + FIRE_W'(1);
      resp_slot  <= idx;
      resp_fired <= 1'b1;
    end
    if (push_pend) begin
      status      <= 1'b0;
      slot_out    <= 4'(resp_slot);
      fired       <= 1'b1;
      last        <= 1'b0;
      tick_count  <= ticks;
      timer_count <= 5'(count);
    end else if (ctl.emit) begin
      status      <= resp_status;
      slot_out    <= 4'(resp_slot);
      fired       <= resp_fired;
      last        <= 1'b1;
      tick_count  <= ticks;
      timer_count <= 5'(count);
    end
  end

endmodule

### hdl/periodic_timer_bank_unit.sv
// Top level of the periodic timer bank: controller and datapath.
//
//   Channel | Handshake          | Payload
//   --------+--------------------+------------------------------------------------
//   input   | in_valid, in_stall | command, slot, interval
//   output  | out_valid, out_stall | status, slot_out, fired, last, tick_count,
//           |                    | timer_count
//
// Tick and dispatch accept the command, then visit each slot in a read state and an
// evaluate state through the single registered read port of the period and remaining
// RAMs, and end in a response state. An allocate with a nonzero interval scans for the
// first free slot one per cycle; every other command, an allocate with a zero interval
// included, goes from the accept straight to the response state.
// Reset (rst, synchronous) clears the used and enabled flags, the tick counter and the
// slot count at once; the RAMs need no clearing pass, as unused slots' entries are ignored.
// A stalled output holds its result; a dispatch waits while a second fired result finds
// the output register still full, and in_stall stays high until the final transfer of a
// command has been loaded into the output register.
module periodic_timer_bank_unit #(
  parameter int NUM_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  command,
  input  logic [3:0]  slot,
  input  logic [31:0] interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        status,
  output logic [3:0]  slot_out,
  output logic        fired,
  output logic        last,
  output logic [31:0] tick_count,
  output logic [4:0]  timer_count
);
  import ptb_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // The controller sequences each command and the per-slot sweeps.
  ptb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  // The datapath holds all slot state and the output register.
  ptb_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .command     (command),
    .slot        (slot),
    .interval    (interval),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .slot_out    (slot_out),
    .fired       (fired),
    .last        (last),
    .tick_count  (tick_count),
    .timer_count (timer_count)
  );

endmodule
